### rtl/bsfr_pkg.sv
package bsfr_pkg;

	// Largest payload a frame may carry, check byte excluded.
	localparam int unsigned MAX_PAYLOAD = 1024;
	localparam int unsigned LEN_W = 11;

	// Escaped pair codes and accepted addresses.
	localparam logic [7:0] ESC_OF_ESC = 8'h7D;
	localparam logic [7:0] ESC_OF_FLAG = 8'h7C;
	localparam logic [7:0] ADDR_A = 8'h01;
	localparam logic [7:0] ADDR_B = 8'h03;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_FLAG = 2'd0;
	localparam logic [1:0] REG_ESCAPE = 2'd1;
	localparam logic [1:0] REG_EXP_CTRL = 2'd2;

	// Reset values of the registers.
	localparam logic [7:0] FLAG_RESET = 8'h5C;
	localparam logic [7:0] ESCAPE_RESET = 8'h5D;
	localparam logic [7:0] EXP_CTRL_RESET = 8'h00;

	// Result kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes.
	localparam logic [2:0] ST_BYTE = 3'd0;
	localparam logic [2:0] ST_DATA_OK = 3'd1;
	localparam logic [2:0] ST_SUPER_OK = 3'd2;
	localparam logic [2:0] ST_CTRL_MISMATCH = 3'd3;
	localparam logic [2:0] ST_HDR_CHECK = 3'd4;
	localparam logic [2:0] ST_DATA_CHECK = 3'd5;
	localparam logic [2:0] ST_BAD_ESC = 3'd6;

	// Live register values seen by the deframer.
	typedef struct packed {
		logic [7:0] flag_value;
		logic [7:0] escape_value;
		logic [7:0] ctrl_expect;
	} bsfr_cfg_t;

	// One result word.
	typedef struct packed {
		logic             kind;
		logic [7:0]       payload_byte;
		logic [2:0]       status;
		logic [LEN_W-1:0] payload_length;
	} bsfr_result_t;

endpackage

### rtl/bsfr_cfg_regs.sv
module bsfr_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output bsfr_pkg::bsfr_cfg_t cfg
);

	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite && pready;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.flag_value <= bsfr_pkg::FLAG_RESET;
			cfg.escape_value <= bsfr_pkg::ESCAPE_RESET;
			cfg.ctrl_expect <= bsfr_pkg::EXP_CTRL_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				bsfr_pkg::REG_FLAG: cfg.flag_value <= pwdata[7:0];
				bsfr_pkg::REG_ESCAPE: cfg.escape_value <= pwdata[7:0];
				bsfr_pkg::REG_EXP_CTRL: cfg.ctrl_expect <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read-back mux; unused addresses read as zero.
	always_comb begin
		unique case (reg_idx)
			bsfr_pkg::REG_FLAG: prdata = {24'd0, cfg.flag_value};
			bsfr_pkg::REG_ESCAPE: prdata = {24'd0, cfg.escape_value};
			bsfr_pkg::REG_EXP_CTRL: prdata = {24'd0, cfg.ctrl_expect};
			default: prdata = 32'd0;
		endcase
	end

endmodule

### rtl/bsfr_deframer.sv
module bsfr_deframer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bsfr_pkg::bsfr_cfg_t    cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	output logic                   res_valid,
	input  logic                   res_ready,
	output bsfr_pkg::bsfr_result_t res
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_FLAG = 3'd1;
	localparam logic [2:0] PH_ADDR = 3'd2;
	localparam logic [2:0] PH_CTRL = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_ESC = 3'd5;

	localparam logic [bsfr_pkg::LEN_W-1:0] MAX_LEN = bsfr_pkg::LEN_W'(bsfr_pkg::MAX_PAYLOAD);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Frame state.
	logic [2:0]                 phase_q, phase_d;
	logic [7:0]                 address_q, address_d;
	logic [7:0]                 control_q, control_d;
	logic [7:0]                 held_q, held_d;
	logic                       held_valid_q, held_valid_d;
	logic [7:0]                 xor_q, xor_d;
	logic [bsfr_pkg::LEN_W-1:0] count_q, count_d;

	// Result register.
	logic                   out_valid_q;
	bsfr_pkg::bsfr_result_t out_q;

	logic                   out_free;
	logic                   step;
	logic                   take_en;
	logic [7:0]             take_data;
	logic                   emit_en;
	logic [2:0]             emit_status;
	logic [bsfr_pkg::LEN_W-1:0] emit_len;
	logic                   gen_valid;
	bsfr_pkg::bsfr_result_t gen;

	// The held byte in the input register moves on when the result slot frees up.
	assign out_free = !out_valid_q || res_ready;
	assign step = valid_s1 && out_free;
	assign in_ready = !valid_s1 || step;
	assign res_valid = out_valid_q;
	assign res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode of one received byte against the frame state.
	always_comb begin
		phase_d = phase_q;
		address_d = address_q;
		control_d = control_q;
		held_d = held_q;
		held_valid_d = held_valid_q;
		xor_d = xor_q;
		count_d = count_q;
		take_en = 1'b0;
		take_data = byte_s1;
		emit_en = 1'b0;
		emit_status = bsfr_pkg::ST_BYTE;
		emit_len = '0;
		gen_valid = 1'b0;
		gen = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == cfg.flag_value) phase_d = PH_FLAG;
			end
			PH_FLAG: begin
				if (byte_s1 != cfg.flag_value &&
				    (byte_s1 == bsfr_pkg::ADDR_A || byte_s1 == bsfr_pkg::ADDR_B)) begin
					address_d = byte_s1;
					held_d = 8'd0;
					held_valid_d = 1'b0;
					xor_d = 8'd0;
					count_d = '0;
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (byte_s1 == cfg.flag_value) begin
					phase_d = PH_FLAG;
				end else if (byte_s1 != cfg.ctrl_expect) begin
					emit_en = 1'b1;
					emit_status = bsfr_pkg::ST_CTRL_MISMATCH;
				end else begin
					control_d = byte_s1;
					phase_d = PH_CTRL;
				end
			end
			PH_CTRL: begin
				if (byte_s1 == (address_q ^ control_q)) begin
					phase_d = PH_DATA;
				end else begin
					emit_en = 1'b1;
					emit_status = bsfr_pkg::ST_HDR_CHECK;
				end
			end
			PH_DATA: begin
				// Escape takes priority when escape and flag share a value.
				if (byte_s1 == cfg.escape_value) begin
					phase_d = PH_ESC;
				end else if (byte_s1 == cfg.flag_value) begin
					emit_en = 1'b1;
					if (!held_valid_q) begin
						emit_status = bsfr_pkg::ST_SUPER_OK;
					end else begin
						emit_len = count_q;
						emit_status = (held_q == xor_q) ? bsfr_pkg::ST_DATA_OK
						                                : bsfr_pkg::ST_DATA_CHECK;
					end
				end else begin
					take_en = 1'b1;
				end
			end
			PH_ESC: begin
				if (byte_s1 == bsfr_pkg::ESC_OF_ESC) begin
					take_en = 1'b1;
					take_data = cfg.escape_value;
				end else if (byte_s1 == bsfr_pkg::ESC_OF_FLAG) begin
					take_en = 1'b1;
					take_data = cfg.flag_value;
				end else begin
					emit_en = 1'b1;
					emit_status = bsfr_pkg::ST_BAD_ESC;
					emit_len = count_q;
				end
			end
			default: phase_d = PH_HUNT;
		endcase

		// A payload byte releases the previously held one, unless the frame is full.
		if (take_en) begin
			if (held_valid_q && count_q >= MAX_LEN) begin
				emit_en = 1'b1;
				emit_status = bsfr_pkg::ST_BAD_ESC;
				emit_len = count_q;
			end else begin
				if (held_valid_q) begin
					gen_valid = 1'b1;
					gen.kind = bsfr_pkg::KIND_BYTE;
					gen.payload_byte = held_q;
					xor_d = xor_q ^ held_q;
					count_d = count_q + 1'b1;
				end
				held_d = take_data;
				held_valid_d = 1'b1;
				phase_d = PH_DATA;
			end
		end

		// Any status report ends the frame.
		if (emit_en) begin
			gen_valid = 1'b1;
			gen.kind = bsfr_pkg::KIND_STATUS;
			gen.payload_byte = 8'd0;
			gen.status = emit_status;
			gen.payload_length = emit_len;
			phase_d = PH_HUNT;
		end
	end

	// Frame state advances only when a byte is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			address_q <= 8'd0;
			control_q <= 8'd0;
			held_q <= 8'd0;
			held_valid_q <= 1'b0;
			xor_q <= 8'd0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			address_q <= address_d;
			control_q <= control_d;
			held_q <= held_d;
			held_valid_q <= held_valid_d;
			xor_q <= xor_d;
			count_q <= count_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && gen_valid) begin
			out_q <= gen;
		end
	end

endmodule

### rtl/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: takes one raw link byte per cycle and sustains that rate
// while no result word is stalled. A byte is registered on acceptance and then decoded
// into a result register; s_tready drops only while the result register holds a word
// that m_tready does not take.
// Released payload bytes come out one byte late (the last one is kept as the XOR check),
// and each frame ends with one status word. Registers: flag at 0x0, escape at 0x4,
// expected control at 0x8; write them only while the stream is idle.
module byte_stuffed_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Received link bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [10:8] status, [21:11] payload_length
	output logic        m_tuser    // [0] kind
);

	bsfr_pkg::bsfr_cfg_t    cfg;
	bsfr_pkg::bsfr_result_t res;

	bsfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsfr_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result word onto the stream.
	assign m_tdata = {2'b00, res.payload_length, res.status, res.payload_byte};
	assign m_tuser = res.kind;

endmodule

### rtl/bsfr_checker.sv
module bsfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// A payload byte word carries no status and no length.
	a_byte_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == bsfr_pkg::KIND_BYTE) |->
		m_tdata[10:8] == bsfr_pkg::ST_BYTE && m_tdata[23:11] == 13'd0)
		else $error("payload byte word has status or length bits set");

	// A status word carries a real status code and no payload byte.
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == bsfr_pkg::KIND_STATUS) |->
		m_tdata[10:8] != bsfr_pkg::ST_BYTE && m_tdata[10:8] != 3'd7 &&
		m_tdata[7:0] == 8'd0 && m_tdata[23:22] == 2'd0)
		else $error("malformed status word");

	// Header failures and supervisory frames report no payload.
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == bsfr_pkg::KIND_STATUS) &&
		(m_tdata[10:8] == bsfr_pkg::ST_SUPER_OK ||
		 m_tdata[10:8] == bsfr_pkg::ST_CTRL_MISMATCH ||
		 m_tdata[10:8] == bsfr_pkg::ST_HDR_CHECK) |-> m_tdata[21:11] == 11'd0)
		else $error("nonzero length on a frame without payload");

	// Reported length never exceeds the payload limit.
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[21:11] <= 11'(bsfr_pkg::MAX_PAYLOAD))
		else $error("payload length beyond limit");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (.*);
